@@ src/pcs_pkg.sv @@
// ----------------------------------------------------------------------------
// PUCT child selector package
// Shared widths, register indexes and the queue entry type.
// ----------------------------------------------------------------------------
package pcs_pkg;

  localparam int VisitBits = 24;
  localparam int PriorBits = 16;
  localparam int ValueBits = 16;
  localparam int RootBits  = 20;
  localparam int DenBits   = VisitBits + 2;
  localparam int QBits     = ValueBits + 1;
  localparam int ScoreBits = 40;
  localparam int IndexBits = 8;
  localparam int ProdBits  = 2 * PriorBits;
  localparam int NumBits   = ProdBits + RootBits;
  localparam int SqrtBits  = VisitBits + 1 + 14;

  // Register indexes of the configuration port.
  localparam logic CFG_EXPLORE_GAIN    = 1'b0;
  localparam logic CFG_UNVISITED_VALUE = 1'b1;

  // One classified edge, as the front hands it to the back.
  typedef struct packed {
    logic                        first;
    logic                        last;
    logic [IndexBits-1:0]        idx;
    logic [VisitBits-1:0]        parent_visits;
    logic [PriorBits-1:0]        edge_prior;
    logic signed [QBits-1:0]     q;
    logic [DenBits-1:0]          den;
  } entry_t;

endpackage

@@ src/pcs_front.sv @@
// ----------------------------------------------------------------------------
// PUCT selector front
// Counts edge positions and forms q and the visit denominator of each edge.
// ----------------------------------------------------------------------------
module pcs_front import pcs_pkg::*; #(
  parameter int MAX_EDGES = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [VisitBits-1:0]  parent_visits,
  input  logic [PriorBits-1:0]  edge_prior,
  input  logic                  child_present,
  input  logic [VisitBits-1:0]  child_visits,
  input  logic [VisitBits-1:0]  child_pending,
  input  logic [ValueBits-1:0]  child_mean,
  input  logic                  last_edge,
  input  logic [ValueBits-1:0]  unvisited_value,
  output entry_t                entry
);

  localparam int PW = (MAX_EDGES > 2) ? $clog2(MAX_EDGES) : 1;
  localparam logic [PW-1:0] POS_MAX = PW'(MAX_EDGES - 1);

  logic [PW-1:0]      pos;
  logic [PW+7:0]      pos_ext;
  logic               visited;

  // Position in the set; holds at the top, returns to zero after the last edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      if (last_edge) begin
        pos <= '0;
      end else if (pos < POS_MAX) begin
        pos <= pos + 1'b1;
      end
    end
  end

  assign pos_ext = {8'b0, pos};
  assign visited = child_present && (child_visits != '0);

  // Classification of the edge.
  always_comb begin
    entry.first         = (pos == '0);
    entry.last          = last_edge;
    entry.idx           = pos_ext[7:0];
    entry.parent_visits = parent_visits;
    entry.edge_prior    = edge_prior;
    if (visited) begin
      entry.q = -{child_mean[ValueBits-1], child_mean};
    end else begin
      entry.q = {unvisited_value[ValueBits-1], unvisited_value};
    end
    if (child_present) begin
      entry.den = DenBits'(1) + DenBits'(child_visits) + DenBits'(child_pending);
    end else begin
      entry.den = DenBits'(1);
    end
  end

endmodule

@@ src/pcs_fifo.sv @@
// ----------------------------------------------------------------------------
// PUCT selector queue
// Two-entry queue of classified edges between front and back.
// ----------------------------------------------------------------------------
module pcs_fifo import pcs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  entry_t  push_data,
  output logic    full,
  input  logic    pop,
  output logic    empty,
  output entry_t  pop_data
);

  entry_t       slots [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = slots[rd_ptr];

  // Pointer and fill bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

endmodule

@@ src/pcs_back.sv @@
// ----------------------------------------------------------------------------
// PUCT selector back
// Square root on a set's first edge, exploration product, serial divide, score and running argmax.
// ----------------------------------------------------------------------------
module pcs_back import pcs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   empty,
  input  entry_t                 pop_data,
  output logic                   pop,
  input  logic [15:0]            explore_gain,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [IndexBits-1:0]   out_index,
  output logic [ScoreBits-1:0]   out_score
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SQRT  = 3'd1;
  localparam logic [2:0] S_MUL1  = 3'd2;
  localparam logic [2:0] S_MUL2  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_SCORE = 3'd5;

  localparam logic signed [ScoreBits-1:0] SCORE_MIN = {1'b1, {(ScoreBits-1){1'b0}}};

  logic [2:0]                   state;
  entry_t                       ent;
  logic [RootBits-1:0]          root;
  logic [ProdBits-1:0]          prod1;
  logic [NumBits-1:0]           div_q;
  logic [DenBits-1:0]           rem;
  logic [5:0]                   div_cnt;
  logic [SqrtBits-1:0]          sq_x;
  logic [SqrtBits:0]            sq_res;
  logic [SqrtBits-1:0]          sq_bit;
  logic signed [ScoreBits-1:0]  lead_score;
  logic [IndexBits-1:0]         best_index;

  logic [SqrtBits:0]            sq_sum;
  logic [DenBits:0]             trial;
  logic                         trial_ge;
  logic signed [ScoreBits-1:0]  score;
  logic                         take;
  logic                         stall;
  logic                         emit;

  assign pop = (state == S_IDLE) && !empty;

  // Square-root step, divide step, score, argmax compare and output stall.
  assign sq_sum   = sq_res + {1'b0, sq_bit};
  assign trial    = {rem, div_q[NumBits-1]};
  assign trial_ge = (trial >= {1'b0, ent.den});
  assign score    = ScoreBits'(ent.q) + ScoreBits'(div_q[NumBits-1:19]);
  assign take     = ent.first || (score > lead_score);
  assign stall    = ent.last && out_valid && !out_ready;
  assign emit     = (state == S_SCORE) && !stall && ent.last;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      lead_score <= SCORE_MIN;
      best_index <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!empty) begin
            state <= pop_data.first ? S_SQRT : S_MUL1;
          end
        end
        S_SQRT: begin
          if (sq_bit[1:0] != 2'b00) state <= S_MUL1;
        end
        S_MUL1: begin
          state <= S_MUL2;
        end
        S_MUL2: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_cnt == 6'(NumBits - 1)) state <= S_SCORE;
        end
        S_SCORE: begin
          if (!stall) begin
            state <= S_IDLE;
            if (ent.last) begin
              lead_score <= SCORE_MIN;
              best_index <= '0;
            end else if (take) begin
              lead_score <= score;
              best_index <= ent.idx;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        ent    <= pop_data;
        sq_x   <= {SqrtBits'(pop_data.parent_visits) + SqrtBits'(1)} << 14;
        sq_res <= '0;
        sq_bit <= {1'b1, {(SqrtBits-1){1'b0}}};
      end
      S_SQRT: begin
        if (sq_x >= sq_sum[SqrtBits-1:0] && !sq_sum[SqrtBits]) begin
          sq_x   <= sq_x - sq_sum[SqrtBits-1:0];
          sq_res <= (sq_res >> 1) + {1'b0, sq_bit};
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
        if (sq_bit[1:0] != 2'b00) begin
          root <= (sq_x >= sq_sum[SqrtBits-1:0] && !sq_sum[SqrtBits])
                  ? RootBits'((sq_res >> 1) + {1'b0, sq_bit})
                  : RootBits'(sq_res >> 1);
        end
      end
      S_MUL1: begin
        prod1 <= explore_gain * ent.edge_prior;
      end
      S_MUL2: begin
        div_q   <= prod1 * root;
        rem     <= '0;
        div_cnt <= '0;
      end
      S_DIV: begin
        if (trial_ge) begin
          rem <= DenBits'(trial - {1'b0, ent.den});
        end else begin
          rem <= trial[DenBits-1:0];
        end
        div_q   <= {div_q[NumBits-2:0], trial_ge};
        div_cnt <= div_cnt + 6'd1;
      end
      S_SCORE: begin
        if (!stall && ent.last) begin
          out_index <= take ? ent.idx : best_index;
          out_score <= take ? score : lead_score;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ src/puct_child_selector_top.sv @@
// ----------------------------------------------------------------------------
// PUCT child selector top level
// Streams the edges of one node and returns the best edge and its score.
// ----------------------------------------------------------------------------
// In the back each edge passes a pop step, two multiply stages, a 52-step
// serial divider and a score step; a set's first edge adds a square root.
// The back finishes one edge before it pops the next.
// A result appears in the cycle after the last edge's score step.
// A two-entry queue lets the input take edges while the back is busy.
// Synchronous reset clears control, restores gain 1.0 and value 0.
module puct_child_selector_top import pcs_pkg::*; #(
  parameter int MAX_EDGES = 256
) (
  input  logic          clk,
  input  logic          rst,
  // parent_visits[23:0], edge_prior[39:24], child_present[40],
  // child_visits[64:41], child_pending[88:65], child_mean[104:89]
  input  logic [111:0]  s_axis_tdata,
  input  logic          s_axis_tlast,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // best_index[7:0], best_score[47:8]
  output logic [47:0]   m_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [15:0]   cfg_data
);

  logic [15:0]            explore_gain;
  logic [15:0]            unvisited_value;
  logic                   accept;
  logic                   full;
  logic                   empty;
  logic                   pop;
  entry_t                 push_data;
  entry_t                 pop_data;
  logic [IndexBits-1:0]   out_index;
  logic [ScoreBits-1:0]   out_score;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      explore_gain    <= 16'd4096;
      unvisited_value <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EXPLORE_GAIN:    explore_gain    <= cfg_data;
        CFG_UNVISITED_VALUE: unvisited_value <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && !full;
  assign m_axis_tdata  = {out_score, out_index};

  pcs_front #(.MAX_EDGES(MAX_EDGES)) u_front (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .parent_visits   (s_axis_tdata[23:0]),
    .edge_prior      (s_axis_tdata[39:24]),
    .child_present   (s_axis_tdata[40]),
    .child_visits    (s_axis_tdata[64:41]),
    .child_pending   (s_axis_tdata[88:65]),
    .child_mean      (s_axis_tdata[104:89]),
    .last_edge       (s_axis_tlast),
    .unvisited_value (unvisited_value),
    .entry           (push_data)
  );

  pcs_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .pop_data  (pop_data)
  );

  pcs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (empty),
    .pop_data     (pop_data),
    .pop          (pop),
    .explore_gain (explore_gain),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_index    (out_index),
    .out_score    (out_score)
  );

endmodule

@@ src/pcs_checker.sv @@
// ----------------------------------------------------------------------------
// PUCT selector port checker
// Watches the top-level ports for output handshake and score range slips.
// ----------------------------------------------------------------------------
module pcs_checker (
  input logic         clk,
  input logic         rst,
  input logic [47:0]  m_axis_tdata,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready
);

  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its data.
  a_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result data changed while stalled");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // Scores stay within what q plus the exploration term can reach.
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[47:42] == 6'h00 || m_axis_tdata[47:42] == 6'h3f))
    else $error("score outside reachable range");

endmodule

bind puct_child_selector_top pcs_checker u_pcs_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
